// ----- sv/sfsr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfsr_pkg
// Shared constants, register codes and the command word passed from the
// classifying front end to the output serializer.
// ----------------------------------------------------------------------------
package sfsr_pkg;

  // character and window geometry
  localparam int CHAR_W      = 8;
  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int CFG_W       = 64;
  localparam int LEN_W       = 4;
  localparam int WIN_W       = PATTERN_MAX * CHAR_W;

  // one command carries at most this many characters
  localparam int MAX_RESULTS = 8;
  localparam int CMD_W       = MAX_RESULTS * CHAR_W;
  localparam int IDX_W       = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_e;

  // a burst of output characters, oldest in the low byte
  typedef struct packed {
    logic [CMD_W-1:0] chars;
    logic [LEN_W-1:0] count;
    logic             last;
    logic             match;
  } sfsr_cmd_t;

endpackage

// ----- sv/sfsr_front.sv -----
// ----------------------------------------------------------------------------
// sfsr_front
// Holds the configuration and the pending-character window, classifies each
// accepted word and issues at most one command for the characters it releases.
// ----------------------------------------------------------------------------
module sfsr_front
  import sfsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // accepted input word
  input  logic                 accept_i,
  input  logic [CHAR_W-1:0]    in_char_i,
  input  logic                 end_of_string_i,
  // command out
  output logic                 cmd_push_o,
  output sfsr_cmd_t            cmd_o
);

  logic [CFG_W-1:0] pattern_bytes_q, replacement_bytes_q;
  logic [LEN_W-1:0] pattern_length_q, replacement_length_q;

  logic [WIN_W-1:0] win_q, win_d;
  logic [LEN_W-1:0] win_cnt_q, win_cnt_d;
  logic             replaced_q, replaced_d;

  logic [LEN_W-1:0] plen, rlen;
  logic [WIN_W-1:0] win_app;
  logic [LEN_W-1:0] cnt_app;
  logic             same;
  logic             room;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q      <= '0;
      pattern_length_q     <= LEN_W'(1);
      replacement_bytes_q  <= '0;
      replacement_length_q <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data_i;
        REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data_i;
        REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths into range
  always_comb begin
    if (pattern_length_q == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_length_q > LEN_W'(PATTERN_MAX)) begin
      plen = LEN_W'(PATTERN_MAX);
    end else begin
      plen = pattern_length_q;
    end
    if (replacement_length_q == '0) begin
      rlen = LEN_W'(1);
    end else if (replacement_length_q > LEN_W'(REPLACE_MAX)) begin
      rlen = LEN_W'(REPLACE_MAX);
    end else begin
      rlen = replacement_length_q;
    end
  end

  // window with the new character appended, and the pattern compare
  assign room = win_cnt_q < LEN_W'(PATTERN_MAX);

  always_comb begin
    win_app = win_q;
    same    = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (room && win_cnt_q == LEN_W'(i)) begin
        win_app[i*CHAR_W +: CHAR_W] = in_char_i;
      end
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < plen &&
          win_app[i*CHAR_W +: CHAR_W] != pattern_bytes_q[i*CHAR_W +: CHAR_W]) begin
        same = 1'b0;
      end
    end
  end

  assign cnt_app = room ? win_cnt_q + LEN_W'(1) : win_cnt_q;

  // classify the word: released characters and next window state
  always_comb begin
    cmd_o       = '0;
    win_d       = win_q;
    win_cnt_d   = win_cnt_q;
    replaced_d  = replaced_q;
    if (replaced_q) begin
      // pass-through after the replacement
      cmd_o.chars = CMD_W'(in_char_i);
      cmd_o.count = LEN_W'(1);
      cmd_o.last  = end_of_string_i;
      cmd_o.match = end_of_string_i;
    end else if (cnt_app == plen && same) begin
      // match: send the replacement, drop the window
      cmd_o.chars = CMD_W'(replacement_bytes_q);
      cmd_o.count = rlen;
      cmd_o.last  = end_of_string_i;
      cmd_o.match = end_of_string_i;
      win_d       = '0;
      win_cnt_d   = '0;
      replaced_d  = 1'b1;
    end else if (end_of_string_i) begin
      // flush everything pending
      cmd_o.chars = CMD_W'(win_app);
      cmd_o.count = cnt_app;
      cmd_o.last  = 1'b1;
      cmd_o.match = 1'b0;
    end else if (cnt_app > plen) begin
      // window over length: release the two oldest
      cmd_o.chars = CMD_W'(win_app);
      cmd_o.count = LEN_W'(2);
      win_d       = win_app >> (2 * CHAR_W);
      win_cnt_d   = cnt_app - LEN_W'(2);
    end else if (cnt_app == plen) begin
      // mismatch: release the oldest
      cmd_o.chars = CMD_W'(win_app);
      cmd_o.count = LEN_W'(1);
      win_d       = win_app >> CHAR_W;
      win_cnt_d   = cnt_app - LEN_W'(1);
    end else begin
      // still filling
      win_d       = win_app;
      win_cnt_d   = cnt_app;
    end
    if (end_of_string_i) begin
      win_d      = '0;
      win_cnt_d  = '0;
      replaced_d = 1'b0;
    end
  end

  assign cmd_push_o = accept_i && cmd_o.count != '0;

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      win_cnt_q  <= '0;
      replaced_q <= 1'b0;
    end else if (accept_i) begin
      win_q      <= win_d;
      win_cnt_q  <= win_cnt_d;
      replaced_q <= replaced_d;
    end
  end

  // window never overfills, and is empty once replaced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cnt_q <= LEN_W'(PATTERN_MAX))
    else $error("window count above pattern maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replaced_q |-> win_cnt_q == '0)
    else $error("window not empty after replacement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_string_i |-> cmd_push_o && cmd_o.last)
    else $error("end of string produced no final word");

endmodule

// ----- sv/sfsr_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// sfsr_cmd_queue
// Small first-in first-out store of commands between front and back.
// ----------------------------------------------------------------------------
module sfsr_cmd_queue
  import sfsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sfsr_cmd_t data_i,
  input  logic      pop_i,
  output sfsr_cmd_t data_o,
  output logic      full_o,
  output logic      empty_o
);

  sfsr_cmd_t          mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      cnt_q <= cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");

endmodule

// ----- sv/sfsr_back.sv -----
// ----------------------------------------------------------------------------
// sfsr_back
// Takes commands from the queue and sends their characters one word per
// cycle into the output register while it is free or being popped.
// ----------------------------------------------------------------------------
module sfsr_back
  import sfsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command queue side
  input  sfsr_cmd_t         cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  // result side
  output logic [CHAR_W-1:0] out_char_o,
  output logic              last_out_o,
  output logic              match_found_o,
  output logic              empty_o,
  input  logic              pop_i
);

  sfsr_cmd_t         cur_q;
  logic              cur_valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q, out_match_q, out_valid_q;

  logic              out_free, emit, last_byte, cur_done;
  logic [CMD_W-1:0]  shifted;

  assign out_free  = !out_valid_q || pop_i;
  assign emit      = cur_valid_q && out_free;
  assign last_byte = {1'b0, idx_q} == cur_q.count - LEN_W'(1);
  assign cur_done  = emit && last_byte;
  assign cmd_pop_o = !cmd_empty_i && (!cur_valid_q || cur_done);
  assign shifted   = cur_q.chars >> {idx_q, 3'b000};

  // current command and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (cmd_pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (cur_done) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (emit) begin
      idx_q       <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= shifted[CHAR_W-1:0];
      out_last_q  <= cur_q.last && last_byte;
      out_match_q <= cur_q.match && last_byte;
    end
  end

  assign out_char_o    = out_char_q;
  assign last_out_o    = out_last_q;
  assign match_found_o = out_match_q;
  assign empty_o       = !out_valid_q;

  // a loaded command is never empty and its index stays inside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> cur_q.count != '0 && {1'b0, idx_q} < cur_q.count)
    else $error("serializer index outside current command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_match_q |-> out_last_q)
    else $error("match flag on a word that is not last");

endmodule

// ----- sv/stream_first_substring_replace_unit.sv -----
// A word's first result passes the command queue, the current-command and
// output registers. Throughput: one input word per cycle while each gives at
// most one result and results are popped; a word releasing k characters holds
// the serializer until all k are sent, and a four-entry command queue absorbs
// such bursts. Reset: asynchronous, active low; clears window, replace flag,
// queue and output; sets pattern/replacement bytes to 0, both lengths to 1.
// ----------------------------------------------------------------------------
// stream_first_substring_replace_unit
// Streaming first-occurrence find and replace over a byte string, split into
// a classifying front end, a command queue and an output serializer.
// ----------------------------------------------------------------------------
module stream_first_substring_replace_unit
  import sfsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input words
  input  logic                 push,
  output logic                 full,
  input  logic [CHAR_W-1:0]    in_char_i,
  input  logic                 end_of_string_i,
  // result words
  output logic                 empty,
  input  logic                 pop,
  output logic [CHAR_W-1:0]    out_char_o,
  output logic                 last_out_o,
  output logic                 match_found_o
);

  logic      accept;
  logic      cmd_push, cmd_pop, q_full, q_empty;
  sfsr_cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  // classify and track the window
  sfsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .in_char_i       (in_char_i),
    .end_of_string_i (end_of_string_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // decoupling queue
  sfsr_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // serialize characters to the output
  sfsr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_head),
    .cmd_empty_i   (q_empty),
    .cmd_pop_o     (cmd_pop),
    .out_char_o    (out_char_o),
    .last_out_o    (last_out_o),
    .match_found_o (match_found_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for stream_first_substring_replace_unit
// Streams byte strings through the block and compares every popped word
// with a cycle-free predictor of the first-match replacement. Directed
// strings come first, then random strings that mostly carry the pattern.
// Both sides stall at random save in the last phase; config changes only when idle.
// ----------------------------------------------------------------------------
module tb
  import sfsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef logic [CHAR_W-1:0] char_t;

  // one result word as the block hands it out
  typedef struct packed {
    char_t chr;
    logic  is_last;
    logic  found;
  } out_word_t;

  // block ports
  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            cfg_valid_i     = 1'b0;
  logic            cfg_ready_o;
  cfg_reg_e        cfg_index_i     = REG_PATTERN_BYTES;
  logic [CFG_W-1:0] cfg_data_i     = '0;
  logic            push            = 1'b0;
  logic            full;
  char_t           in_char_i       = '0;
  logic            end_of_string_i = 1'b0;
  logic            empty;
  logic            pop             = 1'b0;
  char_t           out_char_o;
  logic            last_out_o;
  logic            match_found_o;

  stream_first_substring_replace_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .in_char_i      (in_char_i),
    .end_of_string_i(end_of_string_i),
    .empty          (empty),
    .pop            (pop),
    .out_char_o     (out_char_o),
    .last_out_o     (last_out_o),
    .match_found_o  (match_found_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of registers and window
  logic [CFG_W-1:0] pat_bytes = '0;
  logic [LEN_W-1:0] pat_len   = LEN_W'(1);
  logic [CFG_W-1:0] rep_bytes = '0;
  logic [LEN_W-1:0] rep_len   = LEN_W'(1);
  char_t            win [PATTERN_MAX];
  int unsigned      win_cnt   = 0;
  bit               replaced  = 1'b0;

  out_word_t   expected_q [$];
  out_word_t   due_word;
  int unsigned mismatch_cnt = 0;
  int unsigned words_sent   = 0;
  int unsigned idle_cycles  = 0;
  bit          push_up      = 1'b0;
  bit          sender_stalls = 1'b1;
  bit          calm         = 1'b0;
  int unsigned pop_hold     = 0;
  char_t       alpha [4];

  // lengths of 0 act as 1, above the maximum act as the maximum
  function automatic int unsigned eff_len(logic [LEN_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < PATTERN_MAX; k++) win[k] = '0;
    win_cnt = 0;
  endfunction

  // release the oldest pending character
  function automatic void take_oldest(ref out_word_t burst[$]);
    if (win_cnt == 0) return;
    burst.push_back('{chr: win[0], is_last: 1'b0, found: 1'b0});
    for (int k = 0; k < PATTERN_MAX - 1; k++) win[k] = win[k+1];
    win[PATTERN_MAX-1] = '0;
    win_cnt--;
  endfunction

  // expected output words for one accepted input word
  function automatic void predict_replace(char_t c, logic eos);
    out_word_t   burst [$];
    int unsigned plen;
    int unsigned rlen;
    int unsigned idx;
    bit          same;
    plen = eff_len(pat_len, PATTERN_MAX);
    rlen = eff_len(rep_len, REPLACE_MAX);
    if (replaced) begin
      burst.push_back('{chr: c, is_last: 1'b0, found: 1'b0});
    end else begin
      if (win_cnt < PATTERN_MAX) begin
        win[win_cnt] = c;
        win_cnt++;
      end
      // window over length after a shrink: two oldest go, no compare
      if (win_cnt > plen) begin
        take_oldest(burst);
        take_oldest(burst);
      end else if (win_cnt == plen) begin
        same = 1'b1;
        for (int i = 0; i < plen; i++)
          if (win[i] != pat_bytes[8*i +: 8]) same = 1'b0;
        if (same) begin
          for (int i = 0; i < rlen; i++)
            burst.push_back('{chr: rep_bytes[8*i +: 8], is_last: 1'b0, found: 1'b0});
          clear_window();
          replaced = 1'b1;
        end else begin
          take_oldest(burst);
        end
      end
    end
    // end of string flushes the window and starts a fresh string
    if (eos) begin
      while (win_cnt > 0) take_oldest(burst);
      if (burst.size() > 0) begin
        idx = burst.size() - 1;
        burst[idx].is_last = 1'b1;
        burst[idx].found   = replaced;
      end
      clear_window();
      replaced = 1'b0;
    end
    foreach (burst[k]) expected_q.push_back(burst[k]);
  endfunction

  // send one word, leave push high unless a gap follows
  task automatic send_word(char_t c, logic eos);
    push            <= 1'b1;
    in_char_i       <= c;
    end_of_string_i <= eos;
    push_up = 1'b1;
    do @(posedge clk_i); while (full);
    predict_replace(c, eos);
    words_sent++;
    if (sender_stalls && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      push_up = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic release_push();
    if (push_up) begin
      push <= 1'b0;
      push_up = 1'b0;
      @(posedge clk_i);
    end
  endtask

  // sender waits until every expected word has come and the block settles
  task automatic drain();
    release_push();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PATTERN_BYTES:      pat_bytes = data;
      REG_PATTERN_LENGTH:     pat_len   = data[LEN_W-1:0];
      REG_REPLACEMENT_BYTES:  rep_bytes = data;
      REG_REPLACEMENT_LENGTH: rep_len   = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers, written once the block is idle
  task automatic load_config(logic [CFG_W-1:0] pb, logic [CFG_W-1:0] pl,
                             logic [CFG_W-1:0] rb, logic [CFG_W-1:0] rl);
    drain();
    write_reg(REG_PATTERN_BYTES, pb);
    write_reg(REG_PATTERN_LENGTH, pl);
    write_reg(REG_REPLACEMENT_BYTES, rb);
    write_reg(REG_REPLACEMENT_LENGTH, rl);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset values: zero byte replaced by a zero byte
  task automatic test_reset_config();
    send_word(8'h00, 1'b0);
    send_word(8'h41, 1'b1);
    send_word(8'hFF, 1'b1);
  endtask

  // only the first occurrence goes, short string passes unchanged
  task automatic test_first_match();
    load_config(64'h0000_0000_0063_6261, 64'd3, 64'h0000_0000_0000_5958, 64'd2);
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word("c", 1'b0);
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word("c", 1'b1);
    send_word("a", 1'b0);
    send_word("b", 1'b1);
  endtask

  // full-width pattern and replacement
  task automatic test_extreme_lengths();
    load_config({CFG_W{1'b1}}, 64'd8, 64'h0011_2233_4455_6677, 64'd8);
    for (int k = 0; k < 8; k++) send_word(8'hFF, k == 7);
  endtask

  // zero and oversize lengths, then a length shrunk mid-string
  task automatic test_length_clamp();
    load_config(64'h0000_0000_0000_005A, 64'hFFFF_0000_0000_0000, 64'h5555_AAAA_0F0F_F0F0,
                64'd15);
    send_word(8'h5A, 1'b1);
    load_config(64'h0102_0304_0506_0708, 64'd12, 64'h0000_0000_0000_0080, 64'd0);
    for (int k = 0; k < 5; k++) send_word(char_t'(8'h30 + k), 1'b0);
    load_config(64'h0102_0304_0506_0708, 64'd2, 64'h0000_0000_0000_0080, 64'd0);
    send_word(8'h35, 1'b0);
    send_word(8'h36, 1'b1);
  endtask

  function automatic logic [CFG_W-1:0] roll_length(int unsigned top);
    if ($urandom_range(0, 7) == 0) return {$urandom(), $urandom_range(0, 15)};
    return CFG_W'($urandom_range(1, top));
  endfunction

  // new pattern drawn from a small alphabet so near misses are common
  task automatic roll_config();
    logic [CFG_W-1:0] pb;
    for (int k = 0; k < 4; k++) alpha[k] = char_t'($urandom_range(0, 255));
    for (int k = 0; k < 8; k++) pb[8*k +: 8] = alpha[$urandom_range(0, 3)];
    if ($urandom_range(0, 4) == 0) pb = {$urandom(), $urandom()};
    load_config(pb, roll_length(PATTERN_MAX), {$urandom(), $urandom()},
                roll_length(REPLACE_MAX));
  endtask

  function automatic char_t roll_char();
    case ($urandom_range(0, 9))
      0, 1:    return char_t'($urandom_range(0, 255));
      2, 3, 4: return alpha[$urandom_range(0, 3)];
      default: return pat_bytes[8*$urandom_range(0, 7) +: 8];
    endcase
  endfunction

  // strings that mostly carry the pattern among look-alike characters
  task automatic test_random_strings(int unsigned n_words);
    char_t       text [$];
    int unsigned stop_at;
    int unsigned plen;
    bit          terminate;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) roll_config();
      if (!calm) sender_stalls = $urandom_range(0, 3) != 0;
      text.delete();
      plen = eff_len(pat_len, PATTERN_MAX);
      repeat ($urandom_range(0, 4)) text.push_back(roll_char());
      if ($urandom_range(0, 9) < 6) begin
        for (int k = 0; k < plen; k++) text.push_back(pat_bytes[8*k +: 8]);
        // a broken copy now and then
        if ($urandom_range(0, 4) == 0)
          text[text.size()-1] = char_t'($urandom_range(0, 255));
      end
      repeat ($urandom_range(0, 4)) text.push_back(roll_char());
      if (text.size() == 0) text.push_back(roll_char());
      terminate = $urandom_range(0, 6) != 0;
      foreach (text[k]) send_word(text[k], terminate && (k == text.size() - 1));
    end
  endtask

  // result side stalls at random in bursts, except in the calm phase
  always @(posedge clk_i) begin
    if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      pop_hold <= $urandom_range(0, 10);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic void note_mismatch(string what, out_word_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t %s: expected char %h last %b match %b, got char %h last %b match %b",
               $realtime, what, want.chr, want.is_last, want.found,
               out_char_o, last_out_o, match_found_o);
  endfunction

  // compare each popped word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected word", '0);
      end else begin
        due_word = expected_q.pop_front();
        if (out_char_o !== due_word.chr || last_out_o !== due_word.is_last ||
            match_found_o !== due_word.found)
          note_mismatch("word mismatch", due_word);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // test sequence
  initial begin
    clear_window();
    for (int k = 0; k < 4; k++) alpha[k] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_first_match();
    test_extreme_lengths();
    test_length_clamp();
    test_random_strings(100);
    drain();
    test_random_strings(100);
    calm          = 1'b1;
    sender_stalls = 1'b0;
    test_random_strings(50);
    release_push();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
